// ===== rtl/ufs_pkg.sv =====
// Shared types, constants and scheme tables for the URL field splitter.
// No dependencies; imported by ufs_scan, ufs_desc and url_field_splitter_core.
package ufs_pkg;

    localparam int MAX_URL_LEN = 256;
    localparam int POS_W       = $clog2(MAX_URL_LEN + 2);
    localparam int FIELD_W     = 8;
    localparam int PROTO_W     = 4;
    localparam int BYTE_W      = 8;

    localparam int NUM_SCHEMES = 9;
    localparam int NUM_CAND    = NUM_SCHEMES + 1;
    localparam int CAND_URL    = NUM_SCHEMES;
    localparam int SCH_MAXLEN  = 9;
    localparam int IDX_W       = $clog2(SCH_MAXLEN + 1);

    localparam logic [NUM_CAND-1:0] CAND_ALL     = '1;
    localparam logic [NUM_CAND-1:0] CAND_SCHEMES = NUM_CAND'((1 << NUM_SCHEMES) - 1);

    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_UNKNOWN,
        ST_TOO_LONG
    } status_t;

    // Candidate order: the nine schemes by priority, then the "url:" prefix.
    localparam logic [BYTE_W-1:0] SCH_CHR [NUM_CAND][SCH_MAXLEN] = '{
        '{"h", "t", "t", "p", ":", "/", "/", CH_NUL, CH_NUL},
        '{"f", "t", "p", ":", "/", "/", CH_NUL, CH_NUL, CH_NUL},
        '{"f", "i", "l", "e", ":", "/", "/", CH_NUL, CH_NUL},
        '{"g", "o", "p", "h", "e", "r", ":", "/", "/"},
        '{"m", "a", "i", "l", "t", "o", ":", CH_NUL, CH_NUL},
        '{"n", "e", "w", "s", ":", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"n", "n", "t", "p", ":", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"t", "e", "l", "n", "e", "t", ":", "/", "/"},
        '{"w", "a", "i", "s", ":", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"u", "r", "l", ":", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    localparam logic [IDX_W-1:0] SCH_LEN [NUM_CAND] = '{
        IDX_W'(7), IDX_W'(6), IDX_W'(7), IDX_W'(9), IDX_W'(7),
        IDX_W'(5), IDX_W'(5), IDX_W'(9), IDX_W'(5), IDX_W'(4)
    };

    localparam logic [PROTO_W-1:0] SCH_CODE [NUM_CAND] = '{
        PROTO_W'(1), PROTO_W'(2), PROTO_W'(2), PROTO_W'(3), PROTO_W'(4),
        PROTO_W'(5), PROTO_W'(6), PROTO_W'(7), PROTO_W'(8), PROTO_W'(0)
    };

    typedef struct packed {
        logic               too_long;
        logic               any_ns;
        logic [PROTO_W-1:0] proto;
        logic               saw_lt;
        logic               lnp_gt;
        logic [POS_W-1:0]   lnp;
        logic [POS_W-1:0]   hs;
        logic               h_end_vld;
        logic [POS_W-1:0]   h_end;
        logic               colon;
        logic [POS_W-1:0]   port_start;
        logic               p_end_vld;
        logic [POS_W-1:0]   p_end;
        logic               path_vld;
        logic [POS_W-1:0]   path_start;
        logic               hash_vld;
        logic [POS_W-1:0]   hash;
    } ufs_snap_t;

    typedef struct packed {
        logic [FIELD_W-1:0] section_length;
        logic [FIELD_W-1:0] section_start;
        logic [FIELD_W-1:0] path_length;
        logic [FIELD_W-1:0] path_start;
        logic [FIELD_W-1:0] port_length;
        logic [FIELD_W-1:0] port_start;
        logic [FIELD_W-1:0] host_length;
        logic [FIELD_W-1:0] host_start;
        logic [PROTO_W-1:0] protocol;
        status_t            status;
    } ufs_desc_t;

    localparam int DESC_W       = $bits(ufs_desc_t);
    localparam int OUT_TDATA_W  = ((DESC_W + 7) / 8) * 8;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SP) || (c == CH_CR) || (c == CH_LF) || (c == CH_TAB);
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? c + BYTE_W'(32) : c;
    endfunction

endpackage

// ===== rtl/ufs_scan.sv =====
// Input beat register and per-byte scanner: scheme match, field delimiters, trim marks.
// Depends on ufs_pkg; hands a ufs_snap_t snapshot to ufs_desc on the last beat.
module ufs_scan (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [ufs_pkg::BYTE_W-1:0] s_tdata,   // [7:0] url_byte
    input  logic                     s_tlast,
    output logic                     snap_valid,
    input  logic                     snap_ready,
    output ufs_pkg::ufs_snap_t       snap
);
    import ufs_pkg::*;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_SCHEME,
        PH_URLSP,
        PH_FAIL,
        PH_HOST_FIRST,
        PH_HOST,
        PH_PORT_FIRST,
        PH_PORT,
        PH_PATH,
        PH_SECTION
    } phase_t;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_last_reg;
    logic               snap_valid_reg;
    ufs_snap_t          snap_reg;
    ufs_snap_t          snap_next;

    phase_t             phase_reg,  phase_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [NUM_CAND-1:0] cand_reg,  cand_next;
    logic               saw_lt_reg, saw_lt_next;
    logic               any_ns_reg, any_ns_next;
    logic [POS_W-1:0]   lnp_reg,    lnp_next;
    logic               lnp_gt_reg, lnp_gt_next;
    logic [PROTO_W-1:0] proto_reg,  proto_next;
    logic [POS_W-1:0]   hs_reg,     hs_next;
    logic               h_end_vld_reg, h_end_vld_next;
    logic [POS_W-1:0]   h_end_reg,  h_end_next;
    logic               colon_reg,  colon_next;
    logic [POS_W-1:0]   port_start_reg, port_start_next;
    logic               p_end_vld_reg, p_end_vld_next;
    logic [POS_W-1:0]   p_end_reg,  p_end_next;
    logic               path_vld_reg, path_vld_next;
    logic [POS_W-1:0]   path_start_reg, path_start_next;
    logic               hash_vld_reg, hash_vld_next;
    logic [POS_W-1:0]   hash_reg,   hash_next;

    logic               take;
    logic               is_sp;
    logic [BYTE_W-1:0]  lc;
    logic [POS_W-1:0]   cur;
    logic               m_go;
    logic [IDX_W-1:0]   m_idx;
    logic [NUM_CAND-1:0] m_mask;
    logic [NUM_CAND-1:0] alive;
    logic [NUM_CAND-1:0] done;

    assign take       = in_valid_reg && (!in_last_reg || !snap_valid_reg || snap_ready);
    assign s_tready   = !in_valid_reg || take;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    assign is_sp = is_space(in_byte_reg);
    assign lc    = to_lower(in_byte_reg);
    assign cur   = pos_reg;

    always_comb
    begin
        m_go   = 1'b0;
        m_idx  = idx_reg;
        m_mask = cand_reg;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!is_sp && (in_byte_reg != CH_LT))
                begin
                    m_go   = 1'b1;
                    m_idx  = '0;
                    m_mask = CAND_ALL;
                end
            end
            PH_SCHEME:
            begin
                m_go = 1'b1;
            end
            PH_URLSP:
            begin
                if (in_byte_reg != CH_SP)
                begin
                    m_go   = 1'b1;
                    m_idx  = '0;
                    m_mask = CAND_SCHEMES;
                end
            end
            default:
            begin
                m_go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CAND; c++)
        begin
            alive[c] = m_mask[c] && (m_idx < SCH_LEN[c]) && (lc == SCH_CHR[c][m_idx]);
            done[c]  = alive[c] && (m_idx == SCH_LEN[c] - IDX_W'(1));
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = (pos_reg <= POS_W'(MAX_URL_LEN)) ? pos_reg + POS_W'(1) : pos_reg;
        idx_next        = idx_reg;
        cand_next       = cand_reg;
        saw_lt_next     = saw_lt_reg;
        any_ns_next     = any_ns_reg;
        lnp_next        = lnp_reg;
        lnp_gt_next     = lnp_gt_reg;
        proto_next      = proto_reg;
        hs_next         = hs_reg;
        h_end_vld_next  = h_end_vld_reg;
        h_end_next      = h_end_reg;
        colon_next      = colon_reg;
        port_start_next = port_start_reg;
        p_end_vld_next  = p_end_vld_reg;
        p_end_next      = p_end_reg;
        path_vld_next   = path_vld_reg;
        path_start_next = path_start_reg;
        hash_vld_next   = hash_vld_reg;
        hash_next       = hash_reg;

        if (!is_sp)
        begin
            any_ns_next = 1'b1;
            lnp_next    = cur;
            lnp_gt_next = (in_byte_reg == CH_GT);
        end

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (in_byte_reg == CH_LT)
                begin
                    saw_lt_next = 1'b1;
                    phase_next  = PH_SCHEME;
                    idx_next    = '0;
                    cand_next   = CAND_ALL;
                end
            end
            PH_URLSP:
            begin
                if (in_byte_reg == CH_SP)
                begin
                    phase_next = PH_SCHEME;
                    idx_next   = '0;
                    cand_next  = CAND_SCHEMES;
                end
            end
            PH_HOST_FIRST:
            begin
                phase_next = PH_HOST;
            end
            PH_HOST:
            begin
                if (in_byte_reg == CH_COLON)
                begin
                    h_end_vld_next  = 1'b1;
                    h_end_next      = cur;
                    colon_next      = 1'b1;
                    port_start_next = cur + POS_W'(1);
                    phase_next      = PH_PORT_FIRST;
                end
                else if (in_byte_reg == CH_SLASH)
                begin
                    h_end_vld_next  = 1'b1;
                    h_end_next      = cur;
                    path_vld_next   = 1'b1;
                    path_start_next = cur;
                    phase_next      = PH_PATH;
                end
            end
            PH_PORT_FIRST:
            begin
                phase_next = PH_PORT;
            end
            PH_PORT:
            begin
                if (in_byte_reg == CH_SLASH)
                begin
                    p_end_vld_next  = 1'b1;
                    p_end_next      = cur;
                    path_vld_next   = 1'b1;
                    path_start_next = cur;
                    phase_next      = PH_PATH;
                end
            end
            PH_PATH:
            begin
                if (in_byte_reg == CH_HASH)
                begin
                    hash_vld_next = 1'b1;
                    hash_next     = cur;
                    phase_next    = PH_SECTION;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (m_go)
        begin
            if (done[CAND_URL])
            begin
                phase_next = PH_URLSP;
            end
            else if (|done)
            begin
                for (int c = 0; c < NUM_SCHEMES; c++)
                begin
                    if (done[c])
                    begin
                        proto_next = SCH_CODE[c];
                    end
                end
                hs_next    = cur + POS_W'(1);
                phase_next = PH_HOST_FIRST;
            end
            else if (alive == '0)
            begin
                phase_next = PH_FAIL;
            end
            else
            begin
                phase_next = PH_SCHEME;
                idx_next   = m_idx + IDX_W'(1);
                cand_next  = alive;
            end
        end

        snap_next.too_long   = (pos_reg >= POS_W'(MAX_URL_LEN));
        snap_next.any_ns     = any_ns_next;
        snap_next.proto      = proto_next;
        snap_next.saw_lt     = saw_lt_next;
        snap_next.lnp_gt     = lnp_gt_next;
        snap_next.lnp        = lnp_next;
        snap_next.hs         = hs_next;
        snap_next.h_end_vld  = h_end_vld_next;
        snap_next.h_end      = h_end_next;
        snap_next.colon      = colon_next;
        snap_next.port_start = port_start_next;
        snap_next.p_end_vld  = p_end_vld_next;
        snap_next.p_end      = p_end_next;
        snap_next.path_vld   = path_vld_next;
        snap_next.path_start = path_start_next;
        snap_next.hash_vld   = hash_vld_next;
        snap_next.hash       = hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= '0;
            in_last_reg    <= 1'b0;
            snap_valid_reg <= 1'b0;
            snap_reg       <= '0;
            phase_reg      <= PH_LEAD;
            pos_reg        <= '0;
            idx_reg        <= '0;
            cand_reg       <= CAND_ALL;
            saw_lt_reg     <= 1'b0;
            any_ns_reg     <= 1'b0;
            lnp_reg        <= '0;
            lnp_gt_reg     <= 1'b0;
            proto_reg      <= '0;
            hs_reg         <= '0;
            h_end_vld_reg  <= 1'b0;
            h_end_reg      <= '0;
            colon_reg      <= 1'b0;
            port_start_reg <= '0;
            p_end_vld_reg  <= 1'b0;
            p_end_reg      <= '0;
            path_vld_reg   <= 1'b0;
            path_start_reg <= '0;
            hash_vld_reg   <= 1'b0;
            hash_reg       <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid)
                begin
                    in_byte_reg <= s_tdata;
                    in_last_reg <= s_tlast;
                end
            end

            if (take && in_last_reg)
            begin
                snap_valid_reg <= 1'b1;
                snap_reg       <= snap_next;
            end
            else if (snap_ready)
            begin
                snap_valid_reg <= 1'b0;
            end

            if (take && in_last_reg)
            begin
                phase_reg      <= PH_LEAD;
                pos_reg        <= '0;
                idx_reg        <= '0;
                cand_reg       <= CAND_ALL;
                saw_lt_reg     <= 1'b0;
                any_ns_reg     <= 1'b0;
                lnp_reg        <= '0;
                lnp_gt_reg     <= 1'b0;
                proto_reg      <= '0;
                hs_reg         <= '0;
                h_end_vld_reg  <= 1'b0;
                h_end_reg      <= '0;
                colon_reg      <= 1'b0;
                port_start_reg <= '0;
                p_end_vld_reg  <= 1'b0;
                p_end_reg      <= '0;
                path_vld_reg   <= 1'b0;
                path_start_reg <= '0;
                hash_vld_reg   <= 1'b0;
                hash_reg       <= '0;
            end
            else if (take)
            begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                idx_reg        <= idx_next;
                cand_reg       <= cand_next;
                saw_lt_reg     <= saw_lt_next;
                any_ns_reg     <= any_ns_next;
                lnp_reg        <= lnp_next;
                lnp_gt_reg     <= lnp_gt_next;
                proto_reg      <= proto_next;
                hs_reg         <= hs_next;
                h_end_vld_reg  <= h_end_vld_next;
                h_end_reg      <= h_end_next;
                colon_reg      <= colon_next;
                port_start_reg <= port_start_next;
                p_end_vld_reg  <= p_end_vld_next;
                p_end_reg      <= p_end_next;
                path_vld_reg   <= path_vld_next;
                path_start_reg <= path_start_next;
                hash_vld_reg   <= hash_vld_next;
                hash_reg       <= hash_next;
            end
        end
    end

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_go |-> $onehot0(done))
        else $error("more than one scheme candidate completed on one byte");

    a_scheme_alive: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SCHEME) |-> (cand_reg != '0))
        else $error("scheme phase with no live candidate");

    a_colon_ends_host: assert property (@(posedge clk) disable iff (!rst_n)
        colon_reg |-> h_end_vld_reg)
        else $error("port opened without a host delimiter");

endmodule

// ===== rtl/ufs_desc.sv =====
// Descriptor stage: trims the end mark, truncates field lengths and registers the result.
// Depends on ufs_pkg; fed by ufs_scan, drives the master-side stream.
module ufs_desc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          snap_valid,
    output logic                          snap_ready,
    input  ufs_pkg::ufs_snap_t            snap,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ufs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ufs_pkg::*;

    logic             out_valid_reg;
    ufs_desc_t        desc_reg;
    ufs_desc_t        desc_next;
    logic [POS_W-1:0] end_pos;
    logic             host_ok;
    logic             port_ok;
    logic [POS_W-1:0] host_len;
    logic [POS_W-1:0] port_len;
    logic [POS_W-1:0] path_len;
    logic [POS_W-1:0] sect_start;
    logic [POS_W-1:0] sect_len;

    assign snap_ready = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(OUT_TDATA_W - DESC_W){1'b0}}, desc_reg};

    always_comb
    begin
        end_pos = (snap.saw_lt && snap.lnp_gt) ? snap.lnp : snap.lnp + POS_W'(1);
        host_ok = snap.hs < end_pos;
        port_ok = snap.colon && (snap.port_start < end_pos);

        host_len = '0;
        if (host_ok)
        begin
            host_len = snap.h_end_vld ? snap.h_end - snap.hs : end_pos - snap.hs;
        end

        port_len = '0;
        if (port_ok)
        begin
            port_len = snap.p_end_vld ? snap.p_end - snap.port_start
                                      : end_pos - snap.port_start;
        end

        path_len = '0;
        if (snap.path_vld)
        begin
            path_len = snap.hash_vld ? snap.hash - snap.path_start
                                     : end_pos - snap.path_start;
        end

        sect_start = '0;
        sect_len   = '0;
        if (snap.hash_vld)
        begin
            sect_start = snap.hash + POS_W'(1);
            sect_len   = end_pos - snap.hash - POS_W'(1);
        end

        desc_next = '0;
        priority if (snap.too_long)
        begin
            desc_next.status = ST_TOO_LONG;
        end
        else if (!snap.any_ns)
        begin
            desc_next.status = ST_EMPTY;
        end
        else if (snap.proto == '0)
        begin
            desc_next.status = ST_UNKNOWN;
        end
        else
        begin
            desc_next.status         = ST_OK;
            desc_next.protocol       = snap.proto;
            desc_next.host_start     = snap.hs[FIELD_W-1:0];
            desc_next.host_length    = host_len[FIELD_W-1:0];
            desc_next.port_start     = snap.colon ? snap.port_start[FIELD_W-1:0] : '0;
            desc_next.port_length    = port_len[FIELD_W-1:0];
            desc_next.path_start     = snap.path_vld ? snap.path_start[FIELD_W-1:0] : '0;
            desc_next.path_length    = path_len[FIELD_W-1:0];
            desc_next.section_start  = sect_start[FIELD_W-1:0];
            desc_next.section_length = sect_len[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            desc_reg      <= '0;
        end
        else if (snap_ready)
        begin
            out_valid_reg <= snap_valid;
            if (snap_valid)
            begin
                desc_reg <= desc_next;
            end
        end
    end

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (desc_reg.status != ST_OK)) |->
            (desc_reg.protocol == '0) && (desc_reg.host_start == '0) &&
            (desc_reg.host_length == '0) && (desc_reg.port_start == '0) &&
            (desc_reg.port_length == '0) && (desc_reg.path_start == '0) &&
            (desc_reg.path_length == '0) && (desc_reg.section_start == '0) &&
            (desc_reg.section_length == '0))
        else $error("error descriptor carries field data");

    a_ok_has_protocol: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (desc_reg.status == ST_OK)) |-> (desc_reg.protocol != '0))
        else $error("ok descriptor without protocol");

endmodule

// ===== rtl/url_field_splitter_core.sv =====
// Top level of the URL field splitter: byte stream in, one field descriptor per URL out.
// Depends on ufs_pkg, ufs_scan and ufs_desc.
//
// Slave side: one URL byte per beat in s_tdata[7:0]; s_tlast marks the final byte.
// Master side: one descriptor beat per URL, once its final byte has been scanned.
// Status 0 ok, 1 empty or all whitespace, 2 unknown scheme, 3 longer than
// MAX_URL_LEN bytes; on any nonzero status all other fields are zero.
// Throughput: one byte per cycle while m_tready is high, sustained across URL boundaries.
// The descriptor shows on m_tvalid once the final byte has passed the input register,
// the scan snapshot register and the output register.
// Reset clears the scanner to the leading-whitespace phase at byte offset zero
// and empties all three registers; the first beat after reset starts a new URL.
// When m_tready is low the descriptor holds; the scanner keeps taking bytes
// until the next final byte finds the snapshot register still occupied, then
// s_tready drops until the output drains.
module url_field_splitter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ufs_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] url_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] status, [5:2] protocol, [13:6] host_start, [21:14] host_length,
    // [29:22] port_start, [37:30] port_length, [45:38] path_start,
    // [53:46] path_length, [61:54] section_start, [69:62] section_length, [71:70] zero
    output logic [ufs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import ufs_pkg::*;

    logic      snap_valid;
    logic      snap_ready;
    ufs_snap_t snap;

    ufs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    ufs_desc u_desc (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
